/* design/assert_macros.svh */
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must be followed by another one in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/bta_pkg.sv */
// Shared constants, codes and types of the boundary tag heap allocator.
package bta_pkg;

  localparam int HEAP_WORDS = 4096;
  localparam int ADDR_W     = 12;
  localparam int POS_W      = ADDR_W + 1;
  localparam int TAG_W      = 14;

  typedef enum logic [2:0] {
    OP_ALLOC   = 3'd0,
    OP_FREE    = 3'd1,
    OP_REALLOC = 3'd2,
    OP_ALIGNED = 3'd3,
    OP_SIZE    = 3'd4,
    OP_STATS   = 3'd5,
    OP_INIT    = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    MD_FIND,
    MD_ALLOC,
    MD_ALIGN,
    MD_STATS
  } mode_t;

  typedef enum logic [3:0] {
    ST_CLR0,
    ST_CLR1,
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_APAD,
    ST_AFIT,
    ST_WR,
    ST_FREE_L,
    ST_FREE_LW,
    ST_FREE_R,
    ST_FREE_RW,
    ST_FREE_Q,
    ST_RA_RD,
    ST_RA_CHK,
    ST_DONE
  } state_t;

  // One pending tag write.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [TAG_W-1:0]  data;
  } wr_t;

  typedef wr_t [3:0] wr4_t;

  localparam wr_t WR_OFF = '0;

endpackage

/* design/bta_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
module bta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/boundary_tag_heap_allocator_core.sv */
// Top level of the first-fit boundary tag heap allocator.
//
// The block keeps a heap of 4096 words in which every block carries a signed
// size tag in its first and last word, positive when allocated and negative
// when free. All tags live in one RAM with a registered read. The sequencer
// walks the tag chain from word zero and reads each block boundary in turn:
// address issue, then check. An operation is accepted in the idle state and
// then visits blocks one by one. An aligned allocation also works out the
// padding on every free block that is large enough. A reallocation to a new
// nonzero size reads and checks the block that follows. Every tag update is a
// pass over the write queue. A free reads its left and right neighbors, where
// they exist, and queues its writes before its write pass. A reallocation that
// moves the block runs two write passes with the free in between. The done
// state then hands the result to the output register, and the block stays in
// it as long as the output stays stalled. A size query or free stops at the
// named block, an allocation at the first free block that fits, and a stats
// request walks every block. After reset, and for the init operation, the
// clear states write the end tags of the single free block; no item is
// accepted during the reset pass. A new word is accepted while the previous
// result still waits in the output register.
`include "assert_macros.svh"

module boundary_tag_heap_allocator_core
  import bta_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,       // heap_base_byte_address
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,    // [11:0] block_index, [27:12] byte_count
  input  logic [2:0]  s_axis_tuser,    // [2:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,    // [11:0] result_index, [25:12] size_bytes,
                                       // [40:26] used_bytes, [56:41] free_bytes
  output logic [0:0]  m_axis_tuser     // [0] status
);

  state_t state, state_next;

  logic [31:0]             base;
  logic                    boot;
  logic                    moving;
  logic [2:0]              op;
  logic [ADDR_W-1:0]       idx;
  logic [15:0]             bytes;
  mode_t                   mode;
  logic [POS_W-1:0]        pos;
  logic [POS_W-1:0]        target;
  logic [14:0]             need;
  logic [16:0]             ralign;
  logic [POS_W-1:0]        fsz;
  logic [15:0]             pad;
  logic [POS_W-1:0]        blk;
  logic [POS_W-1:0]        bsize;
  logic [POS_W-1:0]        fstart;
  logic [POS_W-1:0]        fend;
  logic [POS_W-1:0]        ftotal;
  wr_t [5:0]               wq;
  logic [2:0]              wq_idx;
  logic                    r_status;
  logic [ADDR_W-1:0]       r_index;
  logic [13:0]             r_size;
  logic [14:0]             r_used;
  logic [15:0]             r_free;

  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [TAG_W-1:0]        ram_wdata;
  logic [ADDR_W-1:0]       ram_raddr;
  logic [TAG_W-1:0]        ram_rdata;

  bta_ram #(
    .WIDTH(TAG_W),
    .DEPTH(HEAP_WORDS)
  ) u_tags (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Input word fields.
  logic [2:0]        in_op;
  logic [ADDR_W-1:0] in_idx;
  logic [15:0]       in_bytes;
  logic [16:0]       in_align;
  assign in_op    = s_axis_tuser;
  assign in_idx   = s_axis_tdata[11:0];
  assign in_bytes = s_axis_tdata[27:12];

  function automatic logic [14:0] words_for(input logic [15:0] b);
    logic [16:0] sum;
    sum = {1'b0, b} + 17'd3;
    return sum[16:2] + 15'd2;
  endfunction

  // Smallest power of two of at least 32 that covers the request.
  function automatic logic [16:0] align_for(input logic [15:0] b);
    logic [16:0] r;
    r = 17'd32;
    for (int i = 16; i >= 5; i--) begin
      if ((17'd1 << i) >= {1'b0, b}) begin
        r = 17'd1 << i;
      end
    end
    return r;
  endfunction

  assign in_align = align_for(in_bytes);

  function automatic wr_t mk(input logic [POS_W-1:0] a, input logic [TAG_W-1:0] d);
    wr_t w;
    w.en   = 1'b1;
    w.addr = a[ADDR_W-1:0];
    w.data = d;
    return w;
  endfunction

  function automatic logic [TAG_W-1:0] tag_pos(input logic [POS_W-1:0] m);
    return {1'b0, m};
  endfunction

  function automatic logic [TAG_W-1:0] tag_neg(input logic [POS_W-1:0] m);
    return TAG_W'(0) - {1'b0, m};
  endfunction

  // Carve need words out of a free block of fsize words at p; a remainder of
  // fewer than three words stays inside the allocated block.
  function automatic wr4_t place(input logic [POS_W-1:0] p, input logic [POS_W-1:0] fsize,
                                 input logic [14:0] nd);
    wr4_t             w;
    logic [POS_W-1:0] n;
    logic [POS_W-1:0] rem;
    n   = nd[POS_W-1:0];
    rem = fsize - n;
    if (rem >= POS_W'(3)) begin
      w[0] = mk(p, tag_pos(n));
      w[1] = mk(p + n - POS_W'(1), tag_pos(n));
      w[2] = mk(p + n, tag_neg(rem));
      w[3] = mk(p + fsize - POS_W'(1), tag_neg(rem));
    end else begin
      w[0] = mk(p, tag_pos(fsize));
      w[1] = mk(p + fsize - POS_W'(1), tag_pos(fsize));
      w[2] = WR_OFF;
      w[3] = WR_OFF;
    end
    return w;
  endfunction

  // Decode of the tag just read.
  logic [TAG_W-1:0]  tabs;
  logic [POS_W-1:0]  tmag;
  logic              is_free;
  logic              is_used;
  logic [POS_W:0]    step_pos;
  logic              walk_end;
  logic              fit;
  logic [POS_W-1:0]  nxt;
  logic              nxt_ok;
  logic [POS_W-1:0]  nf;
  logic              shrink;
  logic              grow_fit;
  logic              pad_fit;
  logic [POS_W-1:0]  f_shr;
  logic [POS_W-1:0]  tot_shr;
  logic [POS_W-1:0]  end_nxt;
  logic [15:0]       contrib;
  logic [31:0]       addr_b;
  logic [31:0]       neg_addr;
  logic [16:0]       padb;
  logic [17:0]       pad_sum;
  logic [15:0]       pad0;
  logic [POS_W-1:0]  p_al;
  logic              out_free;

  assign tabs     = ram_rdata[TAG_W-1] ? (TAG_W'(0) - ram_rdata) : ram_rdata;
  assign tmag     = tabs[POS_W-1:0];
  assign is_free  = ram_rdata[TAG_W-1];
  assign is_used  = !ram_rdata[TAG_W-1] && (ram_rdata != '0);
  assign step_pos = {1'b0, pos} + {1'b0, tmag};
  assign walk_end = (tmag == '0) || (step_pos >= (POS_W+1)'(HEAP_WORDS));
  assign fit      = is_free && ({2'b0, tmag} >= need);
  assign nxt      = blk + bsize;
  assign nxt_ok   = nxt < POS_W'(HEAP_WORDS);
  assign nf       = (nxt_ok && is_free) ? tmag : '0;
  assign shrink   = need < {2'b0, bsize};
  assign grow_fit = (nf != '0) && ({2'b0, bsize + nf} >= need);
  assign f_shr    = blk + need[POS_W-1:0];
  assign tot_shr  = bsize - need[POS_W-1:0] + nf;
  assign end_nxt  = nxt + nf - POS_W'(1);
  assign pad_fit  = ({1'b0, pad} + {2'b0, need}) <= {4'b0, fsz};
  assign p_al     = pos + pad[POS_W-1:0];
  assign contrib  = {1'b0, tmag, 2'b00} - 16'd8;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Padding in front of an aligned payload, in words.
  assign addr_b   = base + {17'd0, pos + POS_W'(1), 2'b00};
  assign neg_addr = 32'd0 - addr_b;
  assign padb     = neg_addr[16:0] & (ralign - 17'd1);
  assign pad_sum  = {1'b0, padb} + 18'd3;
  assign pad0     = pad_sum[17:2];

  assign s_axis_tready = (state == ST_IDLE);

  // Tag RAM ports.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wq[wq_idx].addr;
    ram_wdata = wq[wq_idx].data;
    unique case (state)
      ST_WR: begin
        ram_we = wq[wq_idx].en;
      end
      ST_CLR0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = tag_neg(POS_W'(HEAP_WORDS));
      end
      ST_CLR1: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(HEAP_WORDS - 1);
        ram_wdata = tag_neg(POS_W'(HEAP_WORDS));
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case (state)
      ST_FREE_L: ram_raddr = ADDR_W'(blk - POS_W'(1));
      ST_FREE_R: ram_raddr = ADDR_W'(fend + POS_W'(1));
      ST_RA_RD:  ram_raddr = nxt[ADDR_W-1:0];
      default:   ram_raddr = pos[ADDR_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR0;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLR0: state_next = ST_CLR1;
      ST_CLR1: state_next = boot ? ST_IDLE : ST_DONE;
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          unique case (in_op)
            OP_ALLOC, OP_ALIGNED: state_next = (in_bytes == '0) ? ST_DONE : ST_RD;
            OP_FREE, OP_SIZE:     state_next = (in_idx == '0) ? ST_DONE : ST_RD;
            OP_REALLOC: begin
              if (in_idx == '0 && in_bytes == '0) begin
                state_next = ST_DONE;
              end else begin
                state_next = ST_RD;
              end
            end
            OP_STATS: state_next = ST_RD;
            OP_INIT:  state_next = ST_CLR0;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_RD: state_next = ST_CHK;
      ST_CHK: begin
        unique case (mode)
          MD_FIND: begin
            if (pos == target) begin
              if (!is_used) begin
                state_next = ST_DONE;
              end else begin
                unique case (op)
                  OP_FREE: state_next = ST_FREE_L;
                  OP_REALLOC: begin
                    if (bytes == '0) begin
                      state_next = ST_FREE_L;
                    end else if (need == {2'b0, tmag}) begin
                      state_next = ST_DONE;
                    end else begin
                      state_next = ST_RA_RD;
                    end
                  end
                  default: state_next = ST_DONE;
                endcase
              end
            end else if (pos > target || walk_end) begin
              state_next = ST_DONE;
            end else begin
              state_next = ST_RD;
            end
          end
          MD_ALLOC: begin
            if (fit) begin
              state_next = ST_WR;
            end else begin
              state_next = walk_end ? ST_DONE : ST_RD;
            end
          end
          MD_ALIGN: begin
            if (fit) begin
              state_next = ST_APAD;
            end else begin
              state_next = walk_end ? ST_DONE : ST_RD;
            end
          end
          MD_STATS: state_next = walk_end ? ST_DONE : ST_RD;
          default:  state_next = ST_DONE;
        endcase
      end
      ST_APAD: state_next = ST_AFIT;
      ST_AFIT: begin
        if (pad_fit) begin
          state_next = ST_WR;
        end else if (({1'b0, pos} + {1'b0, fsz}) >= (POS_W+1)'(HEAP_WORDS)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_RD;
        end
      end
      ST_WR: begin
        if (wq_idx == 3'd5) begin
          state_next = moving ? ST_FREE_L : ST_DONE;
        end
      end
      ST_FREE_L:  state_next = (blk != '0) ? ST_FREE_LW : ST_FREE_R;
      ST_FREE_LW: state_next = ST_FREE_R;
      ST_FREE_R: begin
        if ((fend + POS_W'(1)) < POS_W'(HEAP_WORDS)) begin
          state_next = ST_FREE_RW;
        end else begin
          state_next = ST_FREE_Q;
        end
      end
      ST_FREE_RW: state_next = ST_FREE_Q;
      ST_FREE_Q:  state_next = ST_WR;
      ST_RA_RD:   state_next = ST_RA_CHK;
      ST_RA_CHK:  state_next = (shrink || grow_fit) ? ST_WR : ST_RD;
      ST_DONE:    state_next = out_free ? ST_IDLE : ST_DONE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Datapath and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      base          <= '0;
      boot          <= 1'b1;
      moving        <= 1'b0;
      wq_idx        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        base <= cfg_wdata;
      end
      // A new result may replace the one taken at this same edge.
      if (state == ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLR1: begin
          boot <= 1'b0;
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            op       <= in_op;
            idx      <= in_idx;
            bytes    <= in_bytes;
            pos      <= '0;
            target   <= {1'b0, in_idx} - POS_W'(1);
            moving   <= 1'b0;
            wq_idx   <= '0;
            r_status <= (in_op == OP_STATS || in_op == OP_INIT) ? 1'b0 : 1'b1;
            r_index  <= '0;
            r_size   <= '0;
            r_used   <= '0;
            r_free   <= '0;
            ralign   <= in_align;
            if (in_op == OP_ALIGNED) begin
              need <= in_align[16:2] + 15'd2;
            end else begin
              need <= words_for(in_bytes);
            end
            unique case (in_op)
              OP_FREE, OP_SIZE: mode <= MD_FIND;
              OP_REALLOC:       mode <= (in_idx == '0) ? MD_ALLOC : MD_FIND;
              OP_ALIGNED:       mode <= MD_ALIGN;
              OP_STATS:         mode <= MD_STATS;
              default:          mode <= MD_ALLOC;
            endcase
          end
        end
        ST_CHK: begin
          unique case (mode)
            MD_FIND: begin
              pos <= step_pos[POS_W-1:0];
              if (pos == target && is_used) begin
                blk   <= pos;
                bsize <= tmag;
                unique case (op)
                  OP_SIZE: begin
                    r_size   <= {tmag[11:0] - 12'd2, 2'b00};
                    r_status <= 1'b0;
                  end
                  OP_FREE: begin
                    r_status <= 1'b0;
                  end
                  OP_REALLOC: begin
                    if (bytes == '0) begin
                      r_status <= 1'b0;
                    end else if (need == {2'b0, tmag}) begin
                      r_status <= 1'b0;
                      r_index  <= idx;
                    end
                  end
                  default: begin
                    r_status <= 1'b1;
                  end
                endcase
              end
            end
            MD_ALLOC: begin
              if (fit) begin
                wq       <= {place(pos, tmag, need), WR_OFF, WR_OFF};
                wq_idx   <= '0;
                r_index  <= ADDR_W'(pos + POS_W'(1));
                r_status <= 1'b0;
              end else begin
                pos <= step_pos[POS_W-1:0];
              end
            end
            MD_ALIGN: begin
              if (fit) begin
                fsz <= tmag;
              end else begin
                pos <= step_pos[POS_W-1:0];
              end
            end
            default: begin
              // Stats walk: allocated and free payload totals.
              pos <= step_pos[POS_W-1:0];
              if (tmag != '0) begin
                if (is_free) begin
                  r_free <= r_free + contrib;
                end else begin
                  r_used <= r_used + contrib[14:0];
                end
              end
            end
          endcase
        end
        ST_APAD: begin
          // Too short a gap cannot hold a free block, so move one step on.
          if (pad0 != '0 && pad0 <= 16'd5) begin
            pad <= pad0 + {1'b0, ralign[16:2]};
          end else begin
            pad <= pad0;
          end
        end
        ST_AFIT: begin
          if (pad_fit) begin
            wq_idx   <= '0;
            r_index  <= ADDR_W'(p_al + POS_W'(1));
            r_status <= 1'b0;
            if (pad != '0) begin
              wq <= {place(p_al, fsz - pad[POS_W-1:0], need),
                     mk(p_al - POS_W'(1), tag_neg(pad[POS_W-1:0])),
                     mk(pos, tag_neg(pad[POS_W-1:0]))};
            end else begin
              wq <= {place(pos, fsz, need), WR_OFF, WR_OFF};
            end
          end else begin
            pos <= pos + fsz;
          end
        end
        ST_WR: begin
          if (wq_idx == 3'd5) begin
            wq_idx <= '0;
            moving <= 1'b0;
          end else begin
            wq_idx <= wq_idx + 3'd1;
          end
        end
        ST_FREE_L: begin
          fstart <= blk;
          fend   <= blk + bsize - POS_W'(1);
          ftotal <= bsize;
        end
        ST_FREE_LW: begin
          if (is_free) begin
            fstart <= fstart - tmag;
            ftotal <= ftotal + tmag;
          end
        end
        ST_FREE_RW: begin
          if (is_free) begin
            fend   <= fend + tmag;
            ftotal <= ftotal + tmag;
          end
        end
        ST_FREE_Q: begin
          wq     <= {WR_OFF, WR_OFF, WR_OFF, WR_OFF,
                     mk(fend, tag_neg(ftotal)), mk(fstart, tag_neg(ftotal))};
          wq_idx <= '0;
        end
        ST_RA_CHK: begin
          wq_idx <= '0;
          if (shrink) begin
            // The cut-off tail is freed and joined with a free successor.
            wq       <= {mk(end_nxt, tag_neg(tot_shr)), mk(f_shr, tag_neg(tot_shr)),
                         mk(f_shr - POS_W'(1), tag_pos(need[POS_W-1:0])),
                         mk(blk, tag_pos(need[POS_W-1:0])), WR_OFF, WR_OFF};
            r_status <= 1'b0;
            r_index  <= idx;
          end else if (grow_fit) begin
            wq       <= {place(blk, bsize + nf, need), WR_OFF, WR_OFF};
            r_status <= 1'b0;
            r_index  <= idx;
          end else begin
            // Move: allocate elsewhere first, free the old block afterwards.
            pos    <= '0;
            mode   <= MD_ALLOC;
            moving <= 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_axis_tuser <= r_status;
            m_axis_tdata <= {7'd0, r_free, r_used, r_size, r_index};
          end
        end
        default: begin
          moving <= moving;
        end
      endcase
    end
  end

  `ASSERT_CLK(a_we_states,
              ram_we |-> (state == ST_WR || state == ST_CLR0 || state == ST_CLR1),
              "tag write outside a write state")
  `ASSERT_NEXT(a_done_hold,
               state == ST_DONE && m_axis_tvalid && !m_axis_tready,
               state == ST_DONE, "result dropped while output stalled")
  `ASSERT_CLK(a_rd_range, (state == ST_RD) |-> (pos < POS_W'(HEAP_WORDS)),
              "tag walk beyond heap end")
  `ASSERT_CLK(a_wq_range, (state == ST_WR) |-> (wq_idx <= 3'd5),
              "write queue index out of range")

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the boundary tag heap allocator core.
`timescale 1ns / 100ps

module tb_top
  import bta_pkg::*;
;

  // Clock, reset and the block's ports.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [11:0] block_index, [27:12] byte_count
  logic [2:0]  s_axis_tuser = '0;   // [2:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // [11:0] result_index, [25:12] size_bytes,
                                    // [40:26] used_bytes, [56:41] free_bytes
  logic [0:0]  m_axis_tuser;        // [0] status

  boundary_tag_heap_allocator_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // One result word, unpacked.
  typedef struct packed {
    logic        status;
    logic [11:0] result_index;
    logic [13:0] size_bytes;
    logic [14:0] used_bytes;
    logic [15:0] free_bytes;
  } reply_t;

  // One directed stimulus row; has_exp marks rows whose answer is typed in.
  typedef struct {
    op_t         op;
    logic [11:0] index;
    logic [15:0] bytes;
    bit          has_exp;
    reply_t      exp;
  } row_t;

  // Predictor state: a private copy of the tag heap and of the base address.
  int          tags[HEAP_WORDS];
  logic [31:0] base_addr;

  reply_t replies_due[$];
  int     fail_count;
  int     words_checked;
  int     cycle_count;
  int     idle_in_pct;
  int     stall_out_pct;
  logic [11:0] live_blocks[$];

  function automatic int tag_rd(int i);
    return (i >= 0 && i < HEAP_WORDS) ? tags[i] : 0;
  endfunction

  function automatic void tag_wr(int i, int v);
    if (i >= 0 && i < HEAP_WORDS) tags[i] = v;
  endfunction

  function automatic int mag(int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void heap_reset();
    foreach (tags[i]) tags[i] = 0;
    tags[0] = -HEAP_WORDS;
    tags[HEAP_WORDS-1] = -HEAP_WORDS;
  endfunction

  function automatic int words_needed(int unsigned nbytes);
    return int'((nbytes + 3) / 4) + 2;
  endfunction

  // Start word of the allocated block whose payload sits at idx, else -1.
  function automatic int locate(int unsigned idx);
    int tgt;
    int pos;
    int t;
    if (idx == 0) return -1;
    tgt = int'(idx) - 1;
    pos = 0;
    while (pos < HEAP_WORDS) begin
      t = tags[pos];
      if (pos == tgt) return t > 0 ? pos : -1;
      if (pos > tgt) return -1;
      if (mag(t) <= 0) return -1;
      pos += mag(t);
    end
    return -1;
  endfunction

  // Carve need words out of a free block of fsize words at pos.
  function automatic void carve(int pos, int fsize, int need);
    int rem;
    rem = fsize - need;
    if (rem >= 3) begin
      tag_wr(pos, need);
      tag_wr(pos + need - 1, need);
      tag_wr(pos + need, -rem);
      tag_wr(pos + fsize - 1, -rem);
    end else begin
      tag_wr(pos, fsize);
      tag_wr(pos + fsize - 1, fsize);
    end
  endfunction

  function automatic int unsigned first_fit(int unsigned nbytes);
    int need;
    int pos;
    int t;
    if (nbytes == 0) return 0;
    need = words_needed(nbytes);
    pos = 0;
    while (pos < HEAP_WORDS) begin
      t = tags[pos];
      if (t < 0 && -t >= need) begin
        carve(pos, -t, need);
        return pos + 1;
      end
      if (mag(t) <= 0) return 0;
      pos += mag(t);
    end
    return 0;
  endfunction

  // Free the block at start word s and merge it with free neighbors.
  function automatic void release_block(int s);
    int sz;
    int lo;
    int hi;
    int total;
    sz = tag_rd(s);
    lo = s;
    hi = s + sz - 1;
    total = sz;
    if (lo > 0 && tag_rd(lo - 1) < 0) begin
      total += -tag_rd(lo - 1);
      lo -= -tag_rd(lo - 1);
    end
    if (hi + 1 < HEAP_WORDS && tag_rd(hi + 1) < 0) begin
      total += -tag_rd(hi + 1);
      hi += -tag_rd(hi + 1);
    end
    tag_wr(lo, -total);
    tag_wr(hi, -total);
  endfunction

  function automatic int unsigned aligned_fit(int unsigned nbytes);
    int unsigned b;
    int unsigned r;
    logic [31:0] addr;
    logic [31:0] padb;
    int need;
    int pos;
    int t;
    int fsize;
    int pad;
    int p;
    if (nbytes == 0) return 0;
    b = nbytes < 32 ? 32 : nbytes;
    r = 32;
    while (r < b) r = r << 1;
    need = int'(r / 4) + 2;
    pos = 0;
    while (pos < HEAP_WORDS) begin
      t = tags[pos];
      if (t < 0 && -t >= need) begin
        fsize = -t;
        addr = base_addr + 32'(4 * (pos + 1));
        padb = (32'd0 - addr) & (r - 1);
        pad = int'((padb + 3) / 4);
        if (pad > 0 && pad <= 5) pad += int'(r / 4);
        if (pad + need <= fsize) begin
          p = pos;
          if (pad > 0) begin
            tag_wr(pos, -pad);
            tag_wr(pos + pad - 1, -pad);
            p = pos + pad;
            fsize -= pad;
          end
          carve(p, fsize, need);
          return p + 1;
        end
      end
      if (mag(t) <= 0) return 0;
      pos += mag(t);
    end
    return 0;
  endfunction

  function automatic int unsigned resize(int unsigned idx, int unsigned nbytes,
                                         output bit ok);
    int s;
    int oldsz;
    int newsz;
    int nxt;
    int f;
    int rem;
    int nsz;
    int fs;
    int unsigned r;
    ok = 0;
    if (idx == 0) begin
      r = first_fit(nbytes);
      ok = r != 0;
      return r;
    end
    s = locate(idx);
    if (s < 0) return 0;
    if (nbytes == 0) begin
      release_block(s);
      ok = 1;
      return 0;
    end
    oldsz = tags[s];
    newsz = words_needed(nbytes);
    if (newsz == oldsz) begin
      ok = 1;
      return idx;
    end
    if (newsz < oldsz) begin
      // Shrink in place; the tail may be tiny and merges forward.
      f = s + newsz;
      rem = oldsz - newsz;
      tag_wr(s, newsz);
      tag_wr(s + newsz - 1, newsz);
      tag_wr(f, -rem);
      tag_wr(f + rem - 1, -rem);
      nxt = f + rem;
      if (nxt < HEAP_WORDS && tag_rd(nxt) < 0) begin
        nsz = -tag_rd(nxt);
        tag_wr(f, -(rem + nsz));
        tag_wr(nxt + nsz - 1, -(rem + nsz));
      end
      ok = 1;
      return idx;
    end
    nxt = s + oldsz;
    if (nxt < HEAP_WORDS && tag_rd(nxt) < 0) begin
      fs = -tag_rd(nxt);
      if (oldsz + fs >= newsz) begin
        rem = oldsz + fs - newsz;
        if (rem >= 3) begin
          tag_wr(s, newsz);
          tag_wr(s + newsz - 1, newsz);
          tag_wr(s + newsz, -rem);
          tag_wr(nxt + fs - 1, -rem);
        end else begin
          tag_wr(s, oldsz + fs);
          tag_wr(nxt + fs - 1, oldsz + fs);
        end
        ok = 1;
        return idx;
      end
    end
    // Move: the old block is freed only once the new one is granted.
    r = first_fit(nbytes);
    if (r == 0) return 0;
    release_block(s);
    ok = 1;
    return r;
  endfunction

  // Apply one request word to the private heap and return the expected reply.
  function automatic reply_t heap_apply(op_t op, logic [11:0] idx, logic [15:0] nbytes);
    reply_t rp;
    int s;
    int pos;
    int t;
    bit ok;
    int unsigned used;
    int freeb;
    rp = '0;
    rp.status = 1'b1;
    case (op)
      OP_ALLOC: begin
        rp.result_index = 12'(first_fit(nbytes));
        rp.status = rp.result_index == 0;
      end
      OP_FREE: begin
        s = locate(idx);
        if (s >= 0) begin
          release_block(s);
          rp.status = 1'b0;
        end
      end
      OP_REALLOC: begin
        rp.result_index = 12'(resize(idx, nbytes, ok));
        rp.status = !ok;
      end
      OP_ALIGNED: begin
        rp.result_index = 12'(aligned_fit(nbytes));
        rp.status = rp.result_index == 0;
      end
      OP_SIZE: begin
        s = locate(idx);
        if (s >= 0) begin
          rp.size_bytes = 14'((tags[s] - 2) * 4);
          rp.status = 1'b0;
        end
      end
      OP_STATS: begin
        used = 0;
        freeb = 0;
        pos = 0;
        while (pos < HEAP_WORDS && mag(tags[pos]) > 0) begin
          t = tags[pos];
          if (t > 0) used += t * 4 - 8;
          else freeb += -t * 4 - 8;
          pos += mag(t);
        end
        rp.used_bytes = 15'(used);
        rp.free_bytes = 16'(freeb);
        rp.status = 1'b0;
      end
      OP_INIT: begin
        heap_reset();
        rp.status = 1'b0;
      end
      default: ;
    endcase
    return rp;
  endfunction

  // Hand one request word to the block, with random idle cycles before it.
  // The valid line stays up after an accept until the next word or an idle
  // cycle replaces it; the block is never ready in the cycle after an accept.
  task automatic send_request(logic [2:0] op, logic [11:0] idx, logic [15:0] nbytes,
                              bit has_exp, reply_t typed);
    reply_t rp;
    while ($urandom_range(99) < idle_in_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'd0, nbytes, idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    rp = heap_apply(op_t'(op), idx, nbytes);
    if (has_exp && rp != typed)
      $display("%0t: typed answer disagrees with predictor, exp %h pred %h",
               $time, typed, rp);
    replies_due.push_back(has_exp ? typed : rp);
    // Track granted blocks so later requests name real ones.
    if (rp.status == 1'b0 && rp.result_index != 0) live_blocks.push_back(rp.result_index);
  endtask

  // Wait until every reply has come back, then let the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_base(logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    base_addr = value;
  endtask

  // Receiver: random stalls, every accepted reply checked field by field.
  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (!rst) begin
      m_axis_tready <= $urandom_range(99) >= stall_out_pct;
      if (m_axis_tvalid && m_axis_tready) begin
        got.status       = m_axis_tuser[0];
        got.result_index = m_axis_tdata[11:0];
        got.size_bytes   = m_axis_tdata[25:12];
        got.used_bytes   = m_axis_tdata[40:26];
        got.free_bytes   = m_axis_tdata[56:41];
        words_checked++;
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          if (got.status != want.status) begin
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
            fail_count++;
          end
          if (got.result_index != want.result_index) begin
            $display("%0t: result_index exp %0d got %0d", $time,
                     want.result_index, got.result_index);
            fail_count++;
          end
          if (got.size_bytes != want.size_bytes) begin
            $display("%0t: size_bytes exp %0d got %0d", $time,
                     want.size_bytes, got.size_bytes);
            fail_count++;
          end
          if (got.used_bytes != want.used_bytes) begin
            $display("%0t: used_bytes exp %0d got %0d", $time,
                     want.used_bytes, got.used_bytes);
            fail_count++;
          end
          if (got.free_bytes != want.free_bytes) begin
            $display("%0t: free_bytes exp %0d got %0d", $time,
                     $signed(want.free_bytes), $signed(got.free_bytes));
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog: a reallocation that moves its block walks the chain twice, which
  // sets the worst case for a single word.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 40000000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Pick a block index: mostly a live block, sometimes anything at all.
  function automatic logic [11:0] pick_index();
    int k;
    if (live_blocks.size() != 0 && $urandom_range(99) < 80) begin
      k = $urandom_range(live_blocks.size() - 1);
      return live_blocks[k];
    end
    return 12'($urandom_range(4095));
  endfunction

  // Mostly small requests, a few large ones up to the full byte range.
  function automatic logic [15:0] pick_bytes();
    int sel;
    sel = $urandom_range(99);
    if (sel < 5) return 16'd0;
    if (sel < 75) return 16'($urandom_range(1, 200));
    if (sel < 95) return 16'($urandom_range(1, 2000));
    return 16'($urandom_range(65535));
  endfunction

  // Random phase: allocation-heavy mix with frees to keep the heap churning.
  task automatic random_phase(int count);
    int sel;
    logic [2:0] op;
    reply_t none;
    none = '0;
    repeat (count) begin
      sel = $urandom_range(99);
      if (sel < 25) op = OP_ALLOC;
      else if (sel < 45) op = OP_FREE;
      else if (sel < 62) op = OP_REALLOC;
      else if (sel < 75) op = OP_ALIGNED;
      else if (sel < 85) op = OP_SIZE;
      else if (sel < 94) op = OP_STATS;
      else if (sel < 97) op = OP_INIT;
      else op = 3'd7;
      if (op == OP_INIT) live_blocks.delete();
      send_request(op, (op == OP_REALLOC && $urandom_range(9) == 0) ? 12'd0 : pick_index(),
                   pick_bytes(), 1'b0, none);
    end
  endtask

  row_t plan[$];

  function automatic reply_t typed_reply(logic st, logic [11:0] ri, logic [14:0] ub,
                                         logic [15:0] fb);
    reply_t rp;
    rp = '0;
    rp.status = st;
    rp.result_index = ri;
    rp.used_bytes = ub;
    rp.free_bytes = fb;
    return rp;
  endfunction

  initial begin
    reply_t none;
    none = '0;
    fail_count = 0;
    words_checked = 0;
    cycle_count = 0;
    idle_in_pct = 0;
    stall_out_pct = 0;
    base_addr = '0;
    heap_reset();

    // Directed table: typed answers on a fresh heap after reset or init, and for plain failures.
    plan = '{
      '{OP_STATS,   12'd0,    16'd0,     1, typed_reply(0, 0, 0, 16'd16376)},
      '{OP_ALLOC,   12'd0,    16'd0,     1, typed_reply(1, 0, 0, 0)},
      '{OP_FREE,    12'd0,    16'd0,     1, typed_reply(1, 0, 0, 0)},
      '{OP_SIZE,    12'd4095, 16'd0,     1, typed_reply(1, 0, 0, 0)},
      '{op_t'(3'd7), 12'hFFF, 16'hFFFF,  1, typed_reply(1, 0, 0, 0)},
      '{OP_ALLOC,   12'd0,    16'hFFFF,  1, typed_reply(1, 0, 0, 0)},
      '{OP_ALLOC,   12'd0,    16'd1,     1, typed_reply(0, 1, 0, 0)},
      '{OP_ALLOC,   12'd0,    16'd40,    0, none},
      '{OP_ALLOC,   12'd0,    16'd8,     0, none},
      '{OP_SIZE,    12'd5,    16'd0,     0, none},
      '{OP_FREE,    12'd5,    16'd0,     0, none},
      '{OP_FREE,    12'd5,    16'd0,     0, none},
      '{OP_REALLOC, 12'd1,    16'd120,   0, none},
      '{OP_REALLOC, 12'd1,    16'd20,    0, none},
      '{OP_REALLOC, 12'd1,    16'd21,    0, none},
      '{OP_REALLOC, 12'd0,    16'd64,    0, none},
      '{OP_REALLOC, 12'd7,    16'd4,     0, none},
      '{OP_ALIGNED, 12'd0,    16'd1,     0, none},
      '{OP_ALIGNED, 12'd0,    16'd100,   0, none},
      '{OP_ALIGNED, 12'd0,    16'd4096,  0, none},
      '{OP_REALLOC, 12'd1,    16'd0,     0, none},
      '{OP_ALLOC,   12'd0,    16'd16376, 0, none},
      '{OP_STATS,   12'd0,    16'd0,     0, none},
      '{OP_INIT,    12'd0,    16'd0,     1, typed_reply(0, 0, 0, 0)},
      '{OP_ALLOC,   12'd0,    16'd16376, 1, typed_reply(0, 1, 0, 0)}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i])
      send_request(plan[i].op, plan[i].index, plan[i].bytes, plan[i].has_exp, plan[i].exp);
    drain();
    send_request(OP_INIT, 12'd0, 16'd0, 1'b0, none);
    live_blocks.delete();
    drain();

    // Random phases over several base addresses and idling patterns.
    write_base(32'd4);
    random_phase(110);
    drain();

    write_base(32'hFFFF_FFFC);
    idle_in_pct = 75;
    random_phase(110);
    drain();

    write_base(32'h1234_5678 & 32'hFFFF_FFFC);
    idle_in_pct = 0;
    stall_out_pct = 75;
    random_phase(110);
    drain();

    write_base(32'd0);
    idle_in_pct = 28;
    stall_out_pct = 28;
    random_phase(120);
    drain();

    $display("Checked %0d result words over alloc, free, realloc, aligned alloc, size,",
             words_checked);
    $display("stats, init and invalid requests under four base addresses and idle mixes.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/bta_pkg.sv
design/bta_ram.sv
design/boundary_tag_heap_allocator_core.sv
tb/sv/tb_top.sv
